@@ sv/assert_macros.svh @@
// assertion helpers clocked on clk, disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge
`define SBB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent implies consequent, consequent may be a delayed sequence
`define SBB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ sv/sbb_pkg.sv @@
package sbb_pkg;

	// coordinate and axis component formats
	localparam int COORD_WIDTH = 32;
	localparam int AXIS_WIDTH = 16;
	localparam int AXIS_FRAC = AXIS_WIDTH - 2;

	// product |component| * |half extent| and its rounded, signed form
	localparam int PROD_W = AXIS_WIDTH + COORD_WIDTH;
	localparam int TERM_W = PROD_W - AXIS_FRAC + 1;
	// sum of three terms, then center +/- extent
	localparam int EXT_W = TERM_W + 2;
	localparam int RES_W = EXT_W + 1;

	// shape kinds
	localparam logic [1:0] CMD_SPHERE = 2'd0;
	localparam logic [1:0] CMD_CAPSULE = 2'd1;
	localparam logic [1:0] CMD_BOX = 2'd2;

	localparam logic signed [RES_W-1:0] RES_MAX =
		{{(RES_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
	localparam logic signed [RES_W-1:0] RES_MIN = ~RES_MAX;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [TERM_W-1:0] term_t;
	typedef logic signed [EXT_W-1:0] ext_t;
	typedef logic signed [RES_W-1:0] res_t;

	// clamp a wide result to the signed coordinate range
	function automatic coord_t sat_coord(input res_t v);
		coord_t r;
		if (v > RES_MAX) begin
			r = RES_MAX[COORD_WIDTH-1:0];
		end else if (v < RES_MIN) begin
			r = RES_MIN[COORD_WIDTH-1:0];
		end else begin
			r = v[COORD_WIDTH-1:0];
		end
		return r;
	endfunction

endpackage

@@ sv/shape_bounding_box.sv @@
// Axis-aligned bounding box of one collision shape per item: a sphere gives
// center -/+ radius, a capsule the per-axis min/max of its end points widened
// by the radius, an oriented box center -/+ sum over its three axes of
// |axis component| * half extent (each term rounded to Q16.16, ties away from
// zero, taking the sign of the half extent). All six result fields saturate
// to the signed Q16.16 range; an unknown kind gives an all-zero box. Rate is
// one item per clock: busy stays low and start may be held high every cycle.
// The path is four register stages (input register, nine 16x32 multipliers,
// extent adder and mux, final add with saturation into the output register);
// the result for an item accepted at a rising edge passes through them in that
// order and shows on the outputs with done high. done is high for exactly one
// cycle per item and results cannot be held off: a receiver must take them
// when done is high. There is no configuration and no state across items.
`include "assert_macros.svh"

module shape_bounding_box (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [1:0] command,
	input  logic signed [sbb_pkg::COORD_WIDTH-1:0] p_x,
	input  logic signed [sbb_pkg::COORD_WIDTH-1:0] p_y,
	input  logic signed [sbb_pkg::COORD_WIDTH-1:0] p_z,
	input  logic signed [sbb_pkg::COORD_WIDTH-1:0] q_x,
	input  logic signed [sbb_pkg::COORD_WIDTH-1:0] q_y,
	input  logic signed [sbb_pkg::COORD_WIDTH-1:0] q_z,
	input  logic [sbb_pkg::COORD_WIDTH-2:0] radius,
	input  logic [3*sbb_pkg::AXIS_WIDTH-1:0] axis_first,
	input  logic [3*sbb_pkg::AXIS_WIDTH-1:0] axis_second,
	input  logic [3*sbb_pkg::AXIS_WIDTH-1:0] axis_third,
	output logic done,
	output logic signed [sbb_pkg::COORD_WIDTH-1:0] min_x,
	output logic signed [sbb_pkg::COORD_WIDTH-1:0] min_y,
	output logic signed [sbb_pkg::COORD_WIDTH-1:0] min_z,
	output logic signed [sbb_pkg::COORD_WIDTH-1:0] max_x,
	output logic signed [sbb_pkg::COORD_WIDTH-1:0] max_y,
	output logic signed [sbb_pkg::COORD_WIDTH-1:0] max_z
);
	import sbb_pkg::*;

	localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (AXIS_FRAC - 1);

	logic accept;

	// stage 1: captured item
	logic valid_s1;
	logic [1:0] cmd_s1;
	coord_t p_s1 [3];
	coord_t q_s1 [3];
	logic [COORD_WIDTH-2:0] r_s1;
	logic [3*AXIS_WIDTH-1:0] axis_s1 [3];

	// stage 2: box terms indexed [world axis][box axis], capsule min/max
	logic valid_s2;
	logic [1:0] cmd_s2;
	coord_t p_s2 [3];
	coord_t mn_s2 [3];
	coord_t mx_s2 [3];
	logic [COORD_WIDTH-2:0] r_s2;
	term_t term_s2 [3][3];

	// stage 3: per axis base points and the offset to apply
	logic valid_s3;
	coord_t base_lo_s3 [3];
	coord_t base_hi_s3 [3];
	ext_t off_s3 [3];

	// stage 4: saturated results
	logic valid_s4;
	coord_t lo_s4 [3];
	coord_t hi_s4 [3];

	// combinational helpers
	term_t term_c [3][3];
	coord_t mn_c [3];
	coord_t mx_c [3];
	coord_t base_lo_c [3];
	coord_t base_hi_c [3];
	ext_t off_c [3];
	coord_t lo_c [3];
	coord_t hi_c [3];

	// the pipeline never stalls, so an item is taken whenever start is high
	assign busy = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= command;
			p_s1[0] <= p_x;
			p_s1[1] <= p_y;
			p_s1[2] <= p_z;
			q_s1[0] <= q_x;
			q_s1[1] <= q_y;
			q_s1[2] <= q_z;
			r_s1 <= radius;
			axis_s1[0] <= axis_first;
			axis_s1[1] <= axis_second;
			axis_s1[2] <= axis_third;
		end
	end

	// box terms: round(|a| * |h| / 2^frac), then sign of h
	always_comb begin
		logic [AXIS_WIDTH-1:0] comp;
		logic [AXIS_WIDTH-1:0] amag;
		logic [COORD_WIDTH-1:0] hmag;
		logic [PROD_W-1:0] prod;
		logic [PROD_W-1:0] rnd;
		term_t tmag;
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 3; j++) begin
				comp = axis_s1[j][k*AXIS_WIDTH +: AXIS_WIDTH];
				amag = comp[AXIS_WIDTH-1] ? (~comp + 1'b1) : comp;
				hmag = q_s1[j][COORD_WIDTH-1] ? (~q_s1[j] + 1'b1) : q_s1[j];
				prod = PROD_W'(amag) * PROD_W'(hmag);
				rnd = prod + RND_HALF;
				tmag = signed'({1'b0, rnd[AXIS_FRAC +: TERM_W-1]});
				term_c[k][j] = q_s1[j][COORD_WIDTH-1] ? -tmag : tmag;
			end
		end
	end

	// capsule per-axis ordering of the two end points
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			mn_c[k] = (p_s1[k] < q_s1[k]) ? p_s1[k] : q_s1[k];
			mx_c[k] = (p_s1[k] < q_s1[k]) ? q_s1[k] : p_s1[k];
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			cmd_s2 <= cmd_s1;
			r_s2 <= r_s1;
			p_s2 <= p_s1;
			mn_s2 <= mn_c;
			mx_s2 <= mx_c;
			term_s2 <= term_c;
		end
	end

	// extent sum and per-kind selection of base and offset
	always_comb begin
		ext_t ext;
		ext_t rad;
		rad = EXT_W'(signed'({1'b0, r_s2}));
		for (int k = 0; k < 3; k++) begin
			ext = EXT_W'(term_s2[k][0]) + EXT_W'(term_s2[k][1]) + EXT_W'(term_s2[k][2]);
			unique case (cmd_s2)
				CMD_SPHERE: begin
					base_lo_c[k] = p_s2[k];
					base_hi_c[k] = p_s2[k];
					off_c[k] = rad;
				end
				CMD_CAPSULE: begin
					base_lo_c[k] = mn_s2[k];
					base_hi_c[k] = mx_s2[k];
					off_c[k] = rad;
				end
				CMD_BOX: begin
					base_lo_c[k] = p_s2[k];
					base_hi_c[k] = p_s2[k];
					off_c[k] = ext;
				end
				default: begin
					// unknown kind: all-zero box
					base_lo_c[k] = '0;
					base_hi_c[k] = '0;
					off_c[k] = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			base_lo_s3 <= base_lo_c;
			base_hi_s3 <= base_hi_c;
			off_s3 <= off_c;
		end
	end

	// final add and clamp
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			lo_c[k] = sat_coord(RES_W'(base_lo_s3[k]) - RES_W'(off_s3[k]));
			hi_c[k] = sat_coord(RES_W'(base_hi_s3[k]) + RES_W'(off_s3[k]));
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3) begin
			lo_s4 <= lo_c;
			hi_s4 <= hi_c;
		end
	end

	assign done = valid_s4;
	assign min_x = lo_s4[0];
	assign min_y = lo_s4[1];
	assign min_z = lo_s4[2];
	assign max_x = hi_s4[0];
	assign max_y = hi_s4[1];
	assign max_z = hi_s4[2];

	// terms for the checks below
	logic box_ordered;
	logic box_zero;
	logic cmd_known;

	assign box_ordered = (min_x <= max_x) && (min_y <= max_y) && (min_z <= max_z);
	assign box_zero = (min_x == '0) && (min_y == '0) && (min_z == '0) &&
		(max_x == '0) && (max_y == '0) && (max_z == '0);
	assign cmd_known = (command == CMD_SPHERE) || (command == CMD_CAPSULE) ||
		(command == CMD_BOX);

	// every accepted item comes out with done high
	`SBB_ASSERT_IMP(a_latency, accept, ##4 done, "result strobe missing after accepted item")
	// a sphere box is never inverted
	`SBB_ASSERT_IMP(a_sphere_order, accept && command == CMD_SPHERE, ##4 box_ordered, "sphere box inverted")
	// a capsule box is never inverted
	`SBB_ASSERT_IMP(a_capsule_order, accept && command == CMD_CAPSULE, ##4 box_ordered, "capsule box inverted")
	// unknown kind gives all zeros
	`SBB_ASSERT_IMP(a_unknown_zero, accept && !cmd_known, ##4 box_zero, "unknown kind not zero")

endmodule
